// ===== rtl/core/klock_pkg.sv =====
// Shared types, register map and helpers for the keypad combination lock.
// No dependencies; imported by keypad_combination_lock, klock_monitor and the testbench.
package klock_pkg;

  // Default number of digits in one code entry
  localparam int CODE_LENGTH_DEF = 4;

  // Field widths
  localparam int KEY_W   = 4;
  localparam int MODE_W  = 3;
  localparam int TICK_W  = 7;
  localparam int FAIL_W  = 2;
  localparam int CODE_W  = 8;
  localparam int DIGIT_W = 2;

  // Configuration port
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  // Register indices (byte address / 4)
  localparam logic [1:0] REG_UNLOCK_CODE   = 2'd0;
  localparam logic [1:0] REG_SPLASH_TICKS  = 2'd1;
  localparam logic [1:0] REG_ENTRY_TIMEOUT = 2'd2;
  localparam logic [1:0] REG_FAIL_LIMIT    = 2'd3;

  // Register reset values
  localparam logic [CODE_W-1:0] UNLOCK_CODE_RST   = 8'd228;
  localparam logic [TICK_W-1:0] SPLASH_TICKS_RST  = 7'd100;
  localparam logic [TICK_W-1:0] ENTRY_TIMEOUT_RST = 7'd40;
  localparam logic [FAIL_W-1:0] FAIL_LIMIT_RST    = 2'd2;

  // Saturation limits
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};
  localparam logic [FAIL_W-1:0] FAIL_MAX = {FAIL_W{1'b1}};

  // Lock modes, one-hot
  typedef enum logic [5:0] {
    M_SPLASH = 6'b000001,
    M_ENTRY  = 6'b000010,
    M_CHECK  = 6'b000100,
    M_ALARM  = 6'b001000,
    M_OPEN   = 6'b010000,
    M_RESET  = 6'b100000
  } mode_t;

  // Encoded mode as presented on lock_mode
  localparam logic [MODE_W-1:0] LM_SPLASH = 3'd0;
  localparam logic [MODE_W-1:0] LM_ENTRY  = 3'd1;
  localparam logic [MODE_W-1:0] LM_CHECK  = 3'd2;
  localparam logic [MODE_W-1:0] LM_ALARM  = 3'd3;
  localparam logic [MODE_W-1:0] LM_OPEN   = 3'd4;
  localparam logic [MODE_W-1:0] LM_RESET  = 3'd5;

  function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
    logic [MODE_W-1:0] c;
    case (m)
      M_SPLASH: c = LM_SPLASH;
      M_ENTRY:  c = LM_ENTRY;
      M_CHECK:  c = LM_CHECK;
      M_ALARM:  c = LM_ALARM;
      M_OPEN:   c = LM_OPEN;
      M_RESET:  c = LM_RESET;
      default:  c = LM_SPLASH;
    endcase
    return c;
  endfunction

  // Saturating tick increment
  function automatic logic [TICK_W-1:0] tick_inc(input logic [TICK_W-1:0] t);
    return (t == TICK_MAX) ? t : t + TICK_W'(1);
  endfunction

endpackage

// ===== rtl/core/keypad_combination_lock.sv =====
// Keypad combination lock: mode sequencer, digit capture and code compare.
// Depends on klock_pkg.

// One transaction on the input channel is one timer tick carrying the keys
// pressed during it; each produces exactly one result transaction holding the
// lock state after that tick. The whole tick update is a single register
// stage, so a new tick is taken every cycle while the result register is free
// or being drained. Registers sit at byte addresses 0 (unlock_code), 4
// (splash_ticks), 8 (entry_timeout) and 12 (fail_limit); address bits 1:0
// are ignored. Write them only while the lock is quiet.
module keypad_combination_lock
  import klock_pkg::*;
#(
  parameter int CODE_LENGTH = CODE_LENGTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  // tick input
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KEY_W-1:0]    key_mask,
  // result output
  output logic                out_valid,
  input  logic                out_ready,
  output logic [MODE_W-1:0]   lock_mode,
  output logic [2:0]          digits_entered,
  output logic                alarm_active,
  output logic                door_relay,
  output logic [FAIL_W-1:0]   failures,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  localparam int IDX_W = $clog2(CODE_LENGTH);
  localparam int CNT_W = $clog2(CODE_LENGTH + 1);

  // Configuration registers
  logic [CODE_W-1:0] unlock_code;
  logic [TICK_W-1:0] splash_ticks;
  logic [TICK_W-1:0] entry_timeout;
  logic [FAIL_W-1:0] fail_limit;

  // Lock state
  mode_t              mode, mode_next;
  logic [DIGIT_W-1:0] digit_store [CODE_LENGTH];
  logic [DIGIT_W-1:0] digit_store_next [CODE_LENGTH];
  logic [IDX_W-1:0]   digit_count, digit_count_next;
  logic [TICK_W-1:0]  tick_counter, tick_counter_next;
  logic [FAIL_W-1:0]  fail_counter, fail_counter_next;
  logic               alarm_level, alarm_level_next;
  logic               relay_level, relay_level_next;

  // Key capture results
  logic [DIGIT_W-1:0] cap_store [CODE_LENGTH];
  logic [CNT_W-1:0]   cap_count;
  logic               cap_taken;
  logic               stored_match, cap_match;
  logic [TICK_W-1:0]  tick_up;

  logic in_accept;
  logic cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      unlock_code   <= UNLOCK_CODE_RST;
      splash_ticks  <= SPLASH_TICKS_RST;
      entry_timeout <= ENTRY_TIMEOUT_RST;
      fail_limit    <= FAIL_LIMIT_RST;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_UNLOCK_CODE:   unlock_code   <= pwdata[CODE_W-1:0];
        REG_SPLASH_TICKS:  splash_ticks  <= pwdata[TICK_W-1:0];
        REG_ENTRY_TIMEOUT: entry_timeout <= pwdata[TICK_W-1:0];
        REG_FAIL_LIMIT:    fail_limit    <= pwdata[FAIL_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (paddr[3:2])
      REG_UNLOCK_CODE:   prdata = DATA_W'(unlock_code);
      REG_SPLASH_TICKS:  prdata = DATA_W'(splash_ticks);
      REG_ENTRY_TIMEOUT: prdata = DATA_W'(entry_timeout);
      REG_FAIL_LIMIT:    prdata = DATA_W'(fail_limit);
      default:           prdata = '0;
    endcase
  end

  // Key capture: keys taken in key order while the entry is not full
  always_comb begin
    cap_store = digit_store;
    cap_count = CNT_W'(digit_count);
    cap_taken = 1'b0;
    for (int k = 0; k < KEY_W; k++) begin
      if (key_mask[k] && (cap_count < CNT_W'(CODE_LENGTH))) begin
        cap_store[cap_count[IDX_W-1:0]] = DIGIT_W'(k);
        cap_count = cap_count + CNT_W'(1);
        cap_taken = 1'b1;
      end
    end
  end

  // Code compare, code digit i from unlock_code digit i mod 4
  always_comb begin
    stored_match = 1'b1;
    cap_match    = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (digit_store[i] != unlock_code[2*(i & 3) +: DIGIT_W]) stored_match = 1'b0;
      if (cap_store[i] != unlock_code[2*(i & 3) +: DIGIT_W])   cap_match = 1'b0;
    end
  end

  assign tick_up = tick_inc(cap_taken ? '0 : tick_counter);

  // Tick update
  always_comb begin
    mode_next         = mode;
    digit_store_next  = digit_store;
    digit_count_next  = digit_count;
    tick_counter_next = tick_counter;
    fail_counter_next = fail_counter;
    alarm_level_next  = alarm_level;
    relay_level_next  = relay_level;
    case (mode)
      M_SPLASH: begin
        tick_counter_next = tick_inc(tick_counter);
        if (tick_counter_next >= splash_ticks) mode_next = M_ENTRY;
      end
      M_ENTRY: begin
        digit_store_next  = cap_store;
        digit_count_next  = cap_count[IDX_W-1:0];
        tick_counter_next = tick_up;
        // partial entry left idle too long
        if (tick_up > entry_timeout && cap_count != '0) begin
          tick_counter_next = '0;
          digit_count_next  = '0;
          mode_next         = M_ALARM;
        end
        if (cap_count == CNT_W'(CODE_LENGTH)) begin
          digit_count_next  = '0;
          tick_counter_next = '0;
          mode_next         = M_CHECK;
        end
      end
      M_CHECK: begin
        if (stored_match) begin
          mode_next         = M_OPEN;
          fail_counter_next = '0;
        end else begin
          fail_counter_next = (fail_counter == FAIL_MAX) ? fail_counter
                                                         : fail_counter + FAIL_W'(1);
          mode_next = (fail_counter_next > fail_limit) ? M_ALARM : M_ENTRY;
        end
      end
      M_ALARM: begin
        alarm_level_next = 1'b1;
        mode_next        = M_RESET;
      end
      M_OPEN: begin
        relay_level_next = !relay_level;
        mode_next        = M_ENTRY;
      end
      M_RESET: begin
        digit_store_next  = cap_store;
        digit_count_next  = cap_count[IDX_W-1:0];
        tick_counter_next = cap_taken ? '0 : tick_counter;
        if (cap_count == CNT_W'(CODE_LENGTH)) begin
          digit_count_next = '0;
          if (cap_match) begin
            alarm_level_next  = 1'b0;
            mode_next         = M_ENTRY;
            fail_counter_next = '0;
          end
        end
      end
      default: ;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_SPLASH;
      digit_count  <= '0;
      tick_counter <= '0;
      fail_counter <= '0;
      alarm_level  <= 1'b0;
      relay_level  <= 1'b0;
      for (int i = 0; i < CODE_LENGTH; i++) digit_store[i] <= '0;
    end else if (in_accept) begin
      mode         <= mode_next;
      digit_store  <= digit_store_next;
      digit_count  <= digit_count_next;
      tick_counter <= tick_counter_next;
      fail_counter <= fail_counter_next;
      alarm_level  <= alarm_level_next;
      relay_level  <= relay_level_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      lock_mode      <= mode_code(mode_next);
      digits_entered <= 3'(digit_count_next);
      alarm_active   <= alarm_level_next;
      door_relay     <= relay_level_next;
      failures       <= fail_counter_next;
    end
  end

  // Alarm is raised exactly while waiting for the reset code
  a_alarm_mode: assert property (@(posedge clk) disable iff (rst)
    alarm_level == (mode == M_RESET))
    else $error("alarm level out of step with mode");

  // No digits held in the transient modes
  a_count_clear: assert property (@(posedge clk) disable iff (rst)
    (mode == M_CHECK || mode == M_ALARM || mode == M_OPEN) |-> digit_count == '0)
    else $error("digits held outside entry");

  // Relay only moves on a tick taken in open mode
  a_relay_hold: assert property (@(posedge clk) disable iff (rst)
    !(in_accept && mode == M_OPEN) |=> $stable(relay_level))
    else $error("relay changed outside open mode");

  // Every accepted tick leaves a result pending
  a_result: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> out_valid)
    else $error("accepted tick without result");

endmodule

// ===== tb/klock_monitor.sv =====
// Transaction monitor and result checker for the keypad combination lock.
// Mirrors the lock state per accepted tick and compares every result; uses klock_pkg.
module klock_monitor
  import klock_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [KEY_W-1:0]  key_mask,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic [MODE_W-1:0] lock_mode,
  input  logic [2:0]        digits_entered,
  input  logic              alarm_active,
  input  logic              door_relay,
  input  logic [FAIL_W-1:0] failures,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  input  logic              pready,
  output int                mismatch_count,
  output int                awaiting
);

  localparam int CODE_LEN = CODE_LENGTH_DEF;
  localparam int IDX_W    = $clog2(CODE_LEN);

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [2:0]        digits;
    logic              alarm;
    logic              relay;
    logic [FAIL_W-1:0] fails;
  } lock_view_t;

  lock_view_t expected_states[$];
  lock_view_t seen;
  lock_view_t want;

  // register mirror
  logic [CODE_W-1:0] cfg_code;
  logic [TICK_W-1:0] cfg_splash;
  logic [TICK_W-1:0] cfg_timeout;
  logic [FAIL_W-1:0] cfg_fail_limit;

  // lock state after the last accepted tick
  logic [MODE_W-1:0]  lk_mode;
  logic [DIGIT_W-1:0] digit_mem [CODE_LEN];
  logic [2:0]         digit_cnt;
  logic [TICK_W-1:0]  tick_cnt;
  logic [FAIL_W-1:0]  fail_cnt;
  logic               alarm_lvl;
  logic               relay_lvl;

  // presses taken in key order until the entry is full
  task automatic take_keys(input logic [KEY_W-1:0] keys);
    for (int k = 0; k < KEY_W; k++) begin
      if (keys[k] && digit_cnt < 3'(CODE_LEN)) begin
        digit_mem[digit_cnt[IDX_W-1:0]] = DIGIT_W'(k);
        digit_cnt = digit_cnt + 3'd1;
        tick_cnt = '0;
      end
    end
  endtask

  // code digit i comes from code field i mod 4
  function automatic logic code_hit();
    for (int i = 0; i < CODE_LEN; i++) begin
      if (digit_mem[i] != cfg_code[2*(i%4) +: 2]) return 1'b0;
    end
    return 1'b1;
  endfunction

  // one timer tick of the lock
  task automatic step_lock(input logic [KEY_W-1:0] keys);
    case (lk_mode)
      LM_SPLASH: begin
        if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt >= cfg_splash) lk_mode = LM_ENTRY;
      end
      LM_ENTRY: begin
        take_keys(keys);
        if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 1'b1;
        if (tick_cnt > cfg_timeout && digit_cnt != 3'd0) begin
          tick_cnt = '0;
          digit_cnt = '0;
          lk_mode = LM_ALARM;
        end
        if (digit_cnt == 3'(CODE_LEN)) begin
          digit_cnt = '0;
          tick_cnt = '0;
          lk_mode = LM_CHECK;
        end
      end
      LM_CHECK: begin
        if (code_hit()) begin
          lk_mode = LM_OPEN;
          fail_cnt = '0;
        end else begin
          if (fail_cnt != FAIL_MAX) fail_cnt = fail_cnt + 1'b1;
          lk_mode = (fail_cnt > cfg_fail_limit) ? LM_ALARM : LM_ENTRY;
        end
      end
      LM_ALARM: begin
        alarm_lvl = 1'b1;
        lk_mode = LM_RESET;
      end
      LM_OPEN: begin
        relay_lvl = ~relay_lvl;
        lk_mode = LM_ENTRY;
      end
      LM_RESET: begin
        take_keys(keys);
        if (digit_cnt == 3'(CODE_LEN)) begin
          digit_cnt = '0;
          if (code_hit()) begin
            alarm_lvl = 1'b0;
            lk_mode = LM_ENTRY;
            fail_cnt = '0;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] exp_v,
                             input logic [7:0] got_v);
    if (exp_v !== got_v) begin
      mismatch_count++;
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
    end
  endtask

  // sample both channels and the register port on each rising edge
  always @(posedge clk) begin
    if (rst) begin
      cfg_code = UNLOCK_CODE_RST;
      cfg_splash = SPLASH_TICKS_RST;
      cfg_timeout = ENTRY_TIMEOUT_RST;
      cfg_fail_limit = FAIL_LIMIT_RST;
      lk_mode = LM_SPLASH;
      for (int i = 0; i < CODE_LEN; i++) digit_mem[i] = '0;
      digit_cnt = '0;
      tick_cnt = '0;
      fail_cnt = '0;
      alarm_lvl = 1'b0;
      relay_lvl = 1'b0;
      mismatch_count = 0;
      expected_states.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_UNLOCK_CODE:   cfg_code = pwdata[CODE_W-1:0];
          REG_SPLASH_TICKS:  cfg_splash = pwdata[TICK_W-1:0];
          REG_ENTRY_TIMEOUT: cfg_timeout = pwdata[TICK_W-1:0];
          REG_FAIL_LIMIT:    cfg_fail_limit = pwdata[FAIL_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        step_lock(key_mask);
        expected_states.push_back('{lk_mode, digit_cnt, alarm_lvl, relay_lvl, fail_cnt});
      end
      if (out_valid && out_ready) begin
        seen = '{lock_mode, digits_entered, alarm_active, door_relay, failures};
        if (expected_states.size() == 0) begin
          mismatch_count++;
          $error("result transaction with nothing expected: mode %0d digits %0d",
                 seen.mode, seen.digits);
        end else begin
          want = expected_states.pop_front();
          check_field("lock_mode", 8'(want.mode), 8'(seen.mode));
          check_field("digits_entered", 8'(want.digits), 8'(seen.digits));
          check_field("alarm_active", 8'(want.alarm), 8'(seen.alarm));
          check_field("door_relay", 8'(want.relay), 8'(seen.relay));
          check_field("failures", 8'(want.fails), 8'(seen.fails));
        end
      end
    end
    awaiting <= expected_states.size();
  end

endmodule

// ===== tb/tb_keypad_combination_lock.sv =====
// Stimulus and verdict for the keypad combination lock.
// Drives ticks, register writes and back-pressure; checking lives in klock_monitor.
module tb_keypad_combination_lock;
  import klock_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int TICKS_PER_PHASE = 200;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [KEY_W-1:0]  key_mask = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [MODE_W-1:0] lock_mode;
  logic [2:0]        digits_entered;
  logic              alarm_active;
  logic              door_relay;
  logic [FAIL_W-1:0] failures;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int mismatch_count;
  int awaiting;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int ticks_sent = 0;

  // what the stimulus believes is programmed
  logic [CODE_W-1:0] cur_code = UNLOCK_CODE_RST;
  int                cur_tmo = ENTRY_TIMEOUT_RST;

  keypad_combination_lock DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .key_mask(key_mask),
    .out_valid(out_valid), .out_ready(out_ready),
    .lock_mode(lock_mode), .digits_entered(digits_entered),
    .alarm_active(alarm_active), .door_relay(door_relay), .failures(failures),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  klock_monitor monitor (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .key_mask(key_mask),
    .out_valid(out_valid), .out_ready(out_ready),
    .lock_mode(lock_mode), .digits_entered(digits_entered),
    .alarm_active(alarm_active), .door_relay(door_relay), .failures(failures),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .pready(pready),
    .mismatch_count(mismatch_count), .awaiting(awaiting)
  );

  always #5 clk = ~clk;

  // result side back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL keypad_combination_lock");
      $finish;
    end
  end

  // register write: setup then access phase
  task automatic write_reg(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // one tick transaction, with a random gap in front of it
  task automatic send_tick(input logic [KEY_W-1:0] keys);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    key_mask <= keys;
    do @(posedge clk); while (!in_ready);
    ticks_sent++;
  endtask

  // hold off until every result is back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (awaiting != 0);
    repeat (3) @(posedge clk);
  endtask

  // key in the programmed code (or a corrupted copy), ascending digits
  // sometimes pressed together in one tick
  task automatic key_in_code(input logic wrong);
    logic [1:0]       digs [4];
    logic [KEY_W-1:0] mask;
    int               i;
    int               pos;
    int               gap_max;
    for (int j = 0; j < 4; j++) digs[j] = cur_code[2*j +: 2];
    if (wrong) begin
      pos = $urandom_range(3);
      digs[pos] = digs[pos] + 2'($urandom_range(1, 3));
    end
    gap_max = (cur_tmo > 3) ? 3 : cur_tmo - 1;
    i = 0;
    while (i < 4) begin
      repeat ($urandom_range(gap_max)) send_tick('0);
      mask = KEY_W'(1) << digs[i];
      i++;
      while (i < 4 && digs[i] > digs[i-1] && $urandom_range(2) == 0) begin
        mask = mask | (KEY_W'(1) << digs[i]);
        i++;
      end
      send_tick(mask);
    end
    // let check, open and alarm play out
    repeat ($urandom_range(1, 3)) send_tick('0);
  endtask

  task automatic program_lock(input logic [CODE_W-1:0] code, input int splash,
                              input int tmo, input int flimit);
    write_reg(REG_UNLOCK_CODE, DATA_W'(code));
    write_reg(REG_SPLASH_TICKS, DATA_W'(splash));
    write_reg(REG_ENTRY_TIMEOUT, DATA_W'(tmo));
    write_reg(REG_FAIL_LIMIT, DATA_W'(flimit));
    cur_code = code;
    cur_tmo = tmo;
  endtask

  initial begin
    logic [KEY_W-1:0] opening [24];
    int pick;
    int target;
    opening = '{
      4'h0, 4'hF, 4'h0, 4'h0, 4'h1, 4'h1, 4'h1, 4'h1,
      4'h2, 4'h0, 4'h0, 4'hF, 4'h3, 4'hF, 4'h1, 4'h1,
      4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h0, 4'h0
    };
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // splash counting with the longest splash, then cut short with zero
    write_reg(REG_SPLASH_TICKS, DATA_W'(127));
    send_tick(4'hF);
    send_tick(4'h0);
    settle();
    program_lock(8'h00, 0, 1, 0);
    // leave splash, full entry in one tick, alarm on first failure, reset
    // code, entry timeout, extra presses past a full entry, then an unlock
    foreach (opening[n]) send_tick(opening[n]);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: program_lock(CODE_W'($urandom), 127, 5, 2);
        1: program_lock(8'hFF, 1, 126, 0);
        2: program_lock(CODE_W'($urandom), $urandom_range(127), 127, 3);
        3: program_lock(8'h00, 0, 1, 1);
        default: program_lock(CODE_W'($urandom), $urandom_range(127),
                              $urandom_range(1, 20), $urandom_range(3));
      endcase
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 73; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 73; end
        default: begin send_idle_pct = 38; stall_pct = 38; end
      endcase
      target = ticks_sent + TICKS_PER_PHASE;
      // long wait after one digit: tick counter saturates, the largest
      // timeout never fires
      if (cur_tmo > 20) begin
        send_tick(4'b0100);
        repeat (130) send_tick('0);
      end
      while (ticks_sent < target) begin
        pick = $urandom_range(99);
        if (pick < 55) key_in_code(1'b0);
        else if (pick < 75) key_in_code(1'b1);
        else if (pick < 83 && cur_tmo <= 20) begin
          send_tick(KEY_W'(1) << $urandom_range(3));
          repeat (cur_tmo + 1) send_tick('0);
        end else if (pick < 85) settle();
        else repeat ($urandom_range(1, 4)) send_tick(KEY_W'($urandom_range(15)));
      end
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && awaiting == 0) begin
      $display("PASS keypad_combination_lock");
    end else begin
      $display("FAIL keypad_combination_lock");
    end
    $finish;
  end

endmodule
